### hdl/pva_pkg.sv
`default_nettype none
package pva_pkg;

  localparam int unsigned VoicesDefault = 16;
  localparam int unsigned SlotW = 6;
  localparam int unsigned TagW = 32;
  localparam int unsigned ValW = 16;

  typedef enum logic [0:0] {
    KIND_PLAY   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [TagW-1:0]  request_tag;
    logic [ValW-1:0]  sound_handle;
    logic [ValW-1:0]  volume;
    logic [ValW-1:0]  distance;
    logic [ValW-1:0]  radius;
    logic [SlotW-1:0] slot_index;
  } in_word_t;

  typedef struct packed {
    logic             accepted;
    logic [SlotW-1:0] chosen_slot;
    logic             evicted;
    logic [TagW-1:0]  assigned_tag;
    logic [ValW-1:0]  new_priority;
    logic [ValW-1:0]  played_sound;
  } out_word_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [ValW-1:0]  prio;
    logic [ValW-1:0]  best;
    logic [SlotW-1:0] pick;
    logic             found;
    logic             matched;
    logic             reject;
    logic             evict;
  } search_t;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [ValW-1:0] prio;
  } slot_wr_t;

endpackage
`default_nettype wire

### hdl/pva_div.sv
`default_nettype none
module pva_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [2*pva_pkg::ValW-1:0]  num_i,
  input  wire logic [pva_pkg::ValW-1:0]    den_i,
  output logic                             done_o,
  output logic [pva_pkg::ValW-1:0]         quo_o
);

  logic                     run_q, run_d;
  logic                     done_q, done_d;
  logic [4:0]               cnt_q, cnt_d;
  logic [pva_pkg::ValW-1:0] rem_q, rem_d;
  logic [pva_pkg::ValW-1:0] quo_q, quo_d;
  logic [pva_pkg::ValW-1:0] den_q, den_d;
  logic [pva_pkg::ValW:0]   trial;
  logic [pva_pkg::ValW:0]   diff;

  assign trial = {rem_q, quo_q[pva_pkg::ValW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = num_i[2*pva_pkg::ValW-1:pva_pkg::ValW];
      quo_d = num_i[pva_pkg::ValW-1:0];
      den_d = den_i;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[pva_pkg::ValW-1:0];
        quo_d = {quo_q[pva_pkg::ValW-2:0], 1'b1};
      end else begin
        rem_d = trial[pva_pkg::ValW-1:0];
        quo_d = {quo_q[pva_pkg::ValW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(pva_pkg::ValW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

### hdl/pva_cell.sv
`default_nettype none
module pva_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire pva_pkg::slot_wr_t wr_i,
  input  wire pva_pkg::search_t  sw_i,
  output pva_pkg::search_t       sw_o
);

  localparam logic [pva_pkg::SlotW-1:0] MyIdx = pva_pkg::SlotW'(Idx);

  logic [pva_pkg::TagW-1:0] tag_q;
  logic [pva_pkg::ValW-1:0] prio_q;
  pva_pkg::search_t         sw_q, sw_d;

  always_comb begin
    sw_d = sw_i;
    if (!sw_i.matched && !sw_i.reject) begin
      if (tag_q[pva_pkg::TagW-1:1] == sw_i.tag[pva_pkg::TagW-1:1]) begin
        if (sw_i.tag[0]) begin
          sw_d.reject = 1'b1;
        end else begin
          sw_d.matched = 1'b1;
          sw_d.found   = 1'b1;
          sw_d.pick    = MyIdx;
          sw_d.evict   = (tag_q != '0);
        end
      end else if (prio_q <= sw_i.best) begin
        sw_d.found = 1'b1;
        sw_d.pick  = MyIdx;
        sw_d.best  = prio_q;
        sw_d.evict = (tag_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      prio_q <= '0;
    end else if (we_i) begin
      tag_q  <= wr_i.tag;
      prio_q <= wr_i.prio;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_q <= sw_d;
  end

  assign sw_o = sw_q;

endmodule
`default_nettype wire

### hdl/priority_voice_allocator_top.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i, in_stall_o | in_word_i  (pva_pkg::in_word_t)
// out     | output    | out_valid_o, out_stall_i | out_word_o (pva_pkg::out_word_t)
// A finished event or a request without sound shows its result in the next cycle.
// A play request passes a multiply step, then the divider, then the chain of slot cells
// that its search word runs through; with a zero radius or a distance at or beyond the
// radius the divider is skipped.
// One word is worked on at a time; in_stall_o is high from acceptance until the result
// is taken. Reset clears every slot and the tag counter at once.
`default_nettype none
module priority_voice_allocator_top #(
  parameter int unsigned Voices = pva_pkg::VoicesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pva_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output pva_pkg::out_word_t     out_word_o
);

  localparam int unsigned CntW = $clog2(Voices + 1);
  localparam logic [pva_pkg::SlotW:0] SlotLim = (pva_pkg::SlotW + 1)'(Voices);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [pva_pkg::TagW-1:0]    ctr_q, ctr_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  pva_pkg::in_word_t           req_q, req_d;
  pva_pkg::out_word_t          res_q, res_d;
  logic [2*pva_pkg::ValW-1:0]  num;
  logic [pva_pkg::ValW-1:0]    prio_q, prio_d;
  logic                        div_start;
  logic                        div_done;
  logic [pva_pkg::ValW-1:0]    div_quo;
  pva_pkg::search_t            sw_q, sw_d;
  pva_pkg::search_t            chain [Voices+1];
  logic [Voices-1:0]           we;
  pva_pkg::slot_wr_t           wr;
  logic                        in_acc;
  pva_pkg::search_t            last;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign last       = chain[Voices];
  assign num        = {{pva_pkg::ValW{1'b0}}, req_q.volume}
                    * {{pva_pkg::ValW{1'b0}}, req_q.radius - req_q.distance};

  pva_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (req_q.radius),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign chain[0] = sw_q;

  for (genvar i = 0; i < Voices; i++) begin : g_cell
    pva_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .we_i   (we[i]),
      .wr_i   (wr),
      .sw_i   (chain[i]),
      .sw_o   (chain[i+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    ctr_d     = ctr_q;
    cnt_d     = cnt_q;
    req_d     = req_q;
    res_d     = res_q;
    prio_d    = prio_q;
    sw_d      = sw_q;
    div_start = 1'b0;
    we        = '0;
    wr        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_d = in_word_i;
          res_d = '0;
          if (in_word_i.kind == pva_pkg::KIND_FINISH) begin
            if ({1'b0, in_word_i.slot_index} < SlotLim) begin
              for (int i = 0; i < Voices; i++) begin
                we[i] = (in_word_i.slot_index == pva_pkg::SlotW'(i));
              end
              res_d.accepted    = 1'b1;
              res_d.chosen_slot = in_word_i.slot_index;
            end
            state_d = S_OUT;
          end else if (in_word_i.sound_handle == '0) begin
            state_d = S_OUT;
          end else begin
            if (in_word_i.request_tag[3:1] == 3'd0) begin
              ctr_d             = ctr_q - 1'b1;
              req_d.request_tag = {ctr_d[pva_pkg::TagW-5:0], 4'd0};
            end
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (req_q.radius == '0 || req_q.distance >= req_q.radius) begin
          prio_d  = '0;
          sw_d    = '0;
          sw_d.tag = req_q.request_tag;
          cnt_d   = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_DIV;
        end
        div_start = (state_d == S_DIV);
      end
      S_DIV: begin
        if (div_done) begin
          prio_d   = div_quo;
          sw_d     = '0;
          sw_d.tag = req_q.request_tag;
          sw_d.prio = div_quo;
          sw_d.best = div_quo;
          cnt_d    = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(Voices)) begin
          if (last.found && !last.reject) begin
            for (int i = 0; i < Voices; i++) begin
              we[i] = (last.pick == pva_pkg::SlotW'(i));
            end
            wr.tag              = req_q.request_tag;
            wr.prio             = prio_q;
            res_d.accepted      = 1'b1;
            res_d.chosen_slot   = last.pick;
            res_d.evicted       = last.evict;
            res_d.assigned_tag  = req_q.request_tag;
            res_d.new_priority  = prio_q;
            res_d.played_sound  = req_q.sound_handle;
          end
          cnt_d   = cnt_q;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    prio_q <= prio_d;
    sw_q   <= sw_d;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_word_o  = res_q;

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result word shown twice");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.accepted |-> {1'b0, out_word_o.chosen_slot} < SlotLim)
    else $error("chosen slot out of range");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.accepted |-> out_word_o.assigned_tag == '0
      && out_word_o.played_sound == '0 && out_word_o.evicted == 1'b0)
    else $error("rejected word carries data");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result waits");

endmodule
`default_nettype wire

### verif/pva_checker.sv
`timescale 1ns / 1ps
module pva_checker #(
  parameter int unsigned Voices = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire pva_pkg::in_word_t  in_word_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire pva_pkg::out_word_t out_word_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  logic [31:0]        voice_tag [Voices];
  logic [15:0]        voice_prio [Voices];
  logic [31:0]        fresh_counter;
  pva_pkg::out_word_t expected_words [$];

  function automatic logic [15:0] attenuated_prio(logic [15:0] vol, logic [15:0] dst,
                                                  logic [15:0] rad);
    logic [47:0] num;
    if (rad == 0 || dst >= rad) return 16'd0;
    num = 48'(vol) * 48'(rad - dst);
    return 16'(num / 48'(rad));
  endfunction

  function automatic pva_pkg::out_word_t allocate_voice(pva_pkg::in_word_t w);
    pva_pkg::out_word_t r;
    logic [31:0]        tag;
    logic [15:0]        prio, best;
    int                 pick;
    bit                 found;
    r = '0;
    if (w.kind == pva_pkg::KIND_FINISH) begin
      if (w.slot_index < Voices) begin
        voice_tag[w.slot_index] = '0;
        voice_prio[w.slot_index] = '0;
        r.accepted = 1'b1;
        r.chosen_slot = w.slot_index;
      end
      return r;
    end
    if (w.sound_handle == 0) return r;
    tag = w.request_tag;
    if ((tag & 32'd14) == 0) begin
      fresh_counter = fresh_counter - 1;
      tag = fresh_counter * 32'd16;
    end
    prio = attenuated_prio(w.volume, w.distance, w.radius);
    best = prio;
    pick = 0;
    found = 0;
    for (int i = 0; i < Voices; i++) begin
      if ((voice_tag[i] & ~32'd1) == (tag & ~32'd1)) begin
        if (tag[0]) return r;
        pick = i;
        found = 1;
        break;
      end else if (voice_prio[i] <= best) begin
        pick = i;
        best = voice_prio[i];
        found = 1;
      end
    end
    if (!found) return r;
    r.accepted = 1'b1;
    r.chosen_slot = 6'(pick);
    r.evicted = voice_tag[pick] != 0;
    r.assigned_tag = tag;
    r.new_priority = prio;
    r.played_sound = w.sound_handle;
    voice_tag[pick] = tag;
    voice_prio[pick] = prio;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pva_pkg::out_word_t e;
    if (!rst_ni) begin
      for (int i = 0; i < Voices; i++) begin
        voice_tag[i] = '0;
        voice_prio[i] = '0;
      end
      fresh_counter = '0;
      expected_words.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_words.insert(expected_words.size(), allocate_voice(in_word_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h", out_word_i);
          fail_count_o++;
        end else begin
          e = expected_words.pop_front();
          if (out_word_i.accepted !== e.accepted) begin
            $error("accepted exp %h got %h", e.accepted, out_word_i.accepted);
            fail_count_o++;
          end
          if (out_word_i.chosen_slot !== e.chosen_slot) begin
            $error("chosen_slot exp %h got %h", e.chosen_slot, out_word_i.chosen_slot);
            fail_count_o++;
          end
          if (out_word_i.evicted !== e.evicted) begin
            $error("evicted exp %h got %h", e.evicted, out_word_i.evicted);
            fail_count_o++;
          end
          if (out_word_i.assigned_tag !== e.assigned_tag) begin
            $error("assigned_tag exp %h got %h", e.assigned_tag, out_word_i.assigned_tag);
            fail_count_o++;
          end
          if (out_word_i.new_priority !== e.new_priority) begin
            $error("new_priority exp %h got %h", e.new_priority, out_word_i.new_priority);
            fail_count_o++;
          end
          if (out_word_i.played_sound !== e.played_sound) begin
            $error("played_sound exp %h got %h", e.played_sound, out_word_i.played_sound);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_words.size();
    end
  end
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;

  logic               clk, rst_n;
  logic               in_valid, in_stall, out_valid, out_stall;
  pva_pkg::in_word_t  in_word;
  pva_pkg::out_word_t out_word;
  int                 fail_count, pending;
  bit                 long_hold;

  priority_voice_allocator_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word)
  );

  pva_checker #(.Voices(16)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("priority_voice_allocator_top test failed");
    $finish;
  end

  logic [31:0] tag_pool [8];

  function automatic pva_pkg::in_word_t random_word();
    pva_pkg::in_word_t w;
    w.kind = ($urandom_range(0, 5) == 0) ? pva_pkg::KIND_FINISH : pva_pkg::KIND_PLAY;
    case ($urandom_range(0, 3))
      0: w.request_tag = $urandom;
      1: w.request_tag = $urandom & 32'hFFFF_FFF1;
      default: w.request_tag = tag_pool[$urandom_range(0, 7)] | 32'($urandom_range(0, 1));
    endcase
    w.sound_handle = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
    w.volume = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom);
    w.radius = 16'($urandom);
    w.distance = $urandom_range(0, 1) ? 16'($urandom_range(0, w.radius)) : 16'($urandom);
    if ($urandom_range(0, 15) == 0) w.radius = 0;
    w.slot_index = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 15));
    return w;
  endfunction

  task automatic send(pva_pkg::in_word_t w);
    repeat ($urandom_range(0, 14)) @(posedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic play(logic [31:0] tag, logic [15:0] snd, logic [15:0] vol,
                      logic [15:0] dist_w, logic [15:0] rad);
    pva_pkg::in_word_t w;
    w = '0;
    w.kind = pva_pkg::KIND_PLAY;
    w.request_tag = tag;
    w.sound_handle = snd;
    w.volume = vol;
    w.distance = dist_w;
    w.radius = rad;
    send(w);
  endtask

  task automatic finish_slot(logic [5:0] idx);
    pva_pkg::in_word_t w;
    w = '0;
    w.kind = pva_pkg::KIND_FINISH;
    w.slot_index = idx;
    w.request_tag = '1;
    send(w);
  endtask

  initial begin
    int n;
    for (int i = 0; i < 8; i++) tag_pool[i] = ($urandom & 32'hFFFF_FFF0) | 32'(2 * (i % 7 + 1));
    rst_n = 0;
    in_valid = 0;
    in_word = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    play(32'h0000_0002, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    play(32'h0000_0003, 16'd1, 16'd100, 16'd0, 16'd1);
    play(32'h0000_0002, 16'd5, 16'd0, 16'd0, 16'd0);
    play(32'h0000_0000, 16'h1234, 16'h4000, 16'd10, 16'd20);
    play(32'h0000_0001, 16'd7, 16'h4000, 16'd30, 16'd20);
    play(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    play(32'h8000_000E, 16'd9, 16'hFFFF, 16'd1, 16'hFFFF);
    play(32'h7FFF_FFFE, 16'd9, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    play(32'h7FFF_FFFF, 16'd9, 16'hFFFF, 16'd0, 16'hFFFF);
    for (int i = 0; i < 16; i++) play(32'h100 | 32'(2 * (i % 7 + 1)) | 32'(i << 12),
                                      16'(i + 1), 16'h8000, 16'd0, 16'd1);
    play(32'h0000_0004, 16'd3, 16'd1, 16'd0, 16'd1);
    finish_slot(6'd0);
    finish_slot(6'd15);
    finish_slot(6'd16);
    finish_slot(6'd63);
    wait (pending == 0);
    n = 0;
    while (n < 1270) begin
      send(random_word());
      n++;
      if (n == 400) begin
        long_hold = 1;
        repeat (8) send(random_word());
        n += 8;
        wait (long_hold == 0);
      end
      if (n == 800) wait (pending == 0);
    end
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("priority_voice_allocator_top test passed");
    end else begin
      $display("priority_voice_allocator_top test failed");
    end
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    long_hold = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end
endmodule

### files.f
hdl/pva_pkg.sv
hdl/pva_div.sv
hdl/pva_cell.sv
hdl/priority_voice_allocator_top.sv
verif/pva_checker.sv
verif/tb.sv
